// File: rtl/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// Shared sizes, request and status codes and the per-cell control word of the
// indexed list store.
// ----------------------------------------------------------------------------
package ils_pkg;

	localparam int DEPTH       = 64;
	localparam int DATA_WIDTH  = 32;
	localparam int POS_W       = 6;
	localparam int IO_DATA_W   = 32;
	localparam int COUNT_OUT_W = 7;
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int CMP_W       = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	typedef enum logic [2:0] {
		REQ_INSERT = 3'd0,
		REQ_REMOVE = 3'd1,
		REQ_SET    = 3'd2,
		REQ_GET    = 3'd3,
		REQ_PUSH   = 3'd4,
		REQ_POP    = 3'd5,
		REQ_BACK   = 3'd6,
		REQ_CLEAR  = 3'd7
	} req_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_BADPOS = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD  = 2'd0,
		CELL_WRITE = 2'd1,
		CELL_INS   = 2'd2,
		CELL_DEL   = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t              op;
		logic [CMP_W-1:0]      wpos;
		logic [DATA_WIDTH-1:0] wdata;
		logic                  rd_en;
		logic [CMP_W-1:0]      rpos;
	} cell_ctrl_t;

endpackage

// File: rtl/ils_cell.sv
// ----------------------------------------------------------------------------
// ils_cell
// One list slot: keeps its word, takes new data, or takes a neighbor's word
// when the list opens a gap or closes one.
// ----------------------------------------------------------------------------
module ils_cell import ils_pkg::*; (
	input  logic                  clk,
	input  cell_ctrl_t            ctrl,
	input  logic [CMP_W-1:0]      idx,
	input  logic [DATA_WIDTH-1:0] left,
	input  logic [DATA_WIDTH-1:0] right,
	output logic [DATA_WIDTH-1:0] value,
	output logic [DATA_WIDTH-1:0] rd
);

	logic [DATA_WIDTH-1:0] value_q;
	logic [DATA_WIDTH-1:0] value_d;
	logic                  at_pos;
	logic                  above_pos;

	assign at_pos    = (idx == ctrl.wpos);
	assign above_pos = (idx > ctrl.wpos);

	always_comb begin
		value_d = value_q;
		case (ctrl.op)
			CELL_HOLD: value_d = value_q;
			CELL_WRITE: begin
				if (at_pos) value_d = ctrl.wdata;
			end
			CELL_INS: begin
				if (at_pos) value_d = ctrl.wdata;
				else if (above_pos) value_d = left;
			end
			CELL_DEL: begin
				if (at_pos || above_pos) value_d = right;
			end
			default: value_d = value_q;
		endcase
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

	assign value = value_q;
	// contribution to the wired-or read bus
	assign rd = (ctrl.rd_en && (idx == ctrl.rpos)) ? value_q : '0;

endmodule

// File: rtl/ils_chain.sv
// ----------------------------------------------------------------------------
// ils_chain
// Row of list cells, each linked to both neighbors, with the or-combined
// read bus across all cells.
// ----------------------------------------------------------------------------
module ils_chain import ils_pkg::*; (
	input  logic                  clk,
	input  cell_ctrl_t            ctrl,
	output logic [DATA_WIDTH-1:0] rd_data
);

	logic [DATA_WIDTH-1:0] value [DEPTH];
	logic [DATA_WIDTH-1:0] rd    [DEPTH];
	logic [DEPTH-1:0]      col   [DATA_WIDTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_w;
		logic [DATA_WIDTH-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_left
			assign left_w = value[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_right
			assign right_w = value[i+1];
		end

		ils_cell u_cell (
			.clk   (clk),
			.ctrl  (ctrl),
			.idx   (CMP_W'(i)),
			.left  (left_w),
			.right (right_w),
			.value (value[i]),
			.rd    (rd[i])
		);
	end

	// at most one cell drives a nonzero word, so an or per bit is the read mux
	always_comb begin
		for (int b = 0; b < DATA_WIDTH; b++) begin
			for (int i = 0; i < DEPTH; i++) begin
				col[b][i] = rd[i][b];
			end
			rd_data[b] = |col[b];
		end
	end

endmodule

// File: rtl/indexed_list_store.sv
// ----------------------------------------------------------------------------
// indexed_list_store
// Ordered list of signed words with insert and remove at any position.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the in_ channel (req_type, position, data_in) and
// are taken at a clock edge with in_valid high and in_stall low. Every request
// gives exactly one result on the out_ channel (data_out, status, count_out),
// taken at an edge with out_valid high and out_stall low.
// The result is written into the output register at the edge that takes the
// request. One request per cycle is sustained while the receiver does not
// stall; the list lives in a row of cells that each reload from data_in or a
// neighbor, and reads pass through a single or-combined bus across the row.
// While the receiver stalls, the result holds and in_stall is raised, so no
// further request is taken until the result register frees up (a result taken
// in the same cycle lets a new request in at once).
// Reset empties the list (count 0) and drops any pending result. Stored words
// hold no reset value; positions at or above the count are never read.
// Refused requests (empty, bad position, full) change nothing and return zero
// data.
// ----------------------------------------------------------------------------
module indexed_list_store import ils_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [2:0]                  req_type,
	input  logic [POS_W-1:0]            position,
	input  logic signed [IO_DATA_W-1:0] data_in,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [IO_DATA_W-1:0] data_out,
	output logic [1:0]                  status,
	output logic [COUNT_OUT_W-1:0]      count_out
);

	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     count_d;
	logic                 out_valid_q;
	logic [IO_DATA_W-1:0] data_out_q;
	status_t              status_q;
	logic [CNT_W-1:0]     count_out_q;

	logic                         in_xfer;
	req_t                         req;
	status_t                      st_d;
	cell_ctrl_t                   ctrl;
	logic [CMP_W-1:0]             pos_x;
	logic [CMP_W-1:0]             cnt_x;
	logic                         empty;
	logic                         full;
	logic [DATA_WIDTH-1:0]        rd_data;
	logic signed [DATA_WIDTH-1:0] rd_s;

	assign in_stall = out_valid_q && out_stall;
	assign in_xfer  = in_valid && !in_stall;
	assign req      = req_t'(req_type);
	assign pos_x    = CMP_W'(position);
	assign cnt_x    = CMP_W'(count_q);
	assign empty    = (count_q == '0);
	assign full     = (cnt_x >= CMP_W'(DEPTH));

	always_comb begin
		st_d       = ST_OK;
		count_d    = count_q;
		ctrl.op    = CELL_HOLD;
		ctrl.wpos  = pos_x;
		ctrl.wdata = DATA_WIDTH'(data_in);
		ctrl.rd_en = 1'b0;
		ctrl.rpos  = pos_x;
		case (req)
			REQ_INSERT: begin
				if (pos_x > cnt_x) st_d = ST_BADPOS;
				else if (full) st_d = ST_FULL;
				else begin
					ctrl.op = CELL_INS;
					count_d = count_q + CNT_W'(1);
				end
			end
			REQ_REMOVE, REQ_SET, REQ_GET: begin
				if (empty) st_d = ST_EMPTY;
				else if (pos_x >= cnt_x) st_d = ST_BADPOS;
				else if (req == REQ_REMOVE) begin
					ctrl.op = CELL_DEL;
					count_d = count_q - CNT_W'(1);
				end else if (req == REQ_SET) begin
					ctrl.op = CELL_WRITE;
				end else begin
					ctrl.rd_en = 1'b1;
				end
			end
			REQ_PUSH: begin
				if (full) st_d = ST_FULL;
				else begin
					ctrl.op   = CELL_WRITE;
					ctrl.wpos = cnt_x;
					count_d   = count_q + CNT_W'(1);
				end
			end
			REQ_POP: begin
				if (empty) st_d = ST_EMPTY;
				else count_d = count_q - CNT_W'(1);
			end
			REQ_BACK: begin
				if (empty) st_d = ST_EMPTY;
				else begin
					ctrl.rd_en = 1'b1;
					ctrl.rpos  = cnt_x - CMP_W'(1);
				end
			end
			REQ_CLEAR: count_d = '0;
			default: st_d = ST_OK;
		endcase
		// cells only move on a real transfer
		if (!in_xfer) begin
			ctrl.op    = CELL_HOLD;
			ctrl.rd_en = 1'b0;
		end
	end

	ils_chain u_chain (
		.clk     (clk),
		.ctrl    (ctrl),
		.rd_data (rd_data)
	);

	assign rd_s = rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			data_out_q  <= IO_DATA_W'(rd_s);
			status_q    <= st_d;
			count_out_q <= count_d;
		end
	end

	assign out_valid = out_valid_q;
	assign data_out  = data_out_q;
	assign status    = status_q;
	assign count_out = COUNT_OUT_W'(count_out_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && (req == REQ_INSERT || req == REQ_PUSH) && st_d == ST_OK)
		|=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("accepted insert did not grow the list");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && req == REQ_CLEAR) |=> (count_q == '0 && status_q == ST_OK))
		else $error("clear did not empty the list");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_OK) |-> (data_out_q == '0))
		else $error("refused request returned data");

	a_result_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (count_out_q == count_q || in_xfer == 1'b0 || !out_stall))
		else $error("result count out of step with list");

endmodule
